### hdl/affinity_channel_allocator_core_assert.svh
// Assertion macros for the affinity channel allocator core.
// Used by files that include this header; they rely on clk and rst_n in scope.
`ifndef AFFINITY_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`define AFFINITY_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ACA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ACA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/aca_pkg.sv
// Shared constants, codes and types for the affinity channel allocator.
// No dependencies; imported by aca_front, aca_back and the top level.
package aca_pkg;

  // The channel field is 3 bits wide, which fixes the table at eight channels.
  localparam int CHANNELS    = 8;
  localparam int CHAN_W      = 3;
  localparam int SERVER_W    = 8;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 4;

  // Request queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLAIM = 2'd2;

  // Request classes carried through the queue.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CLAIM = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREEFREE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_REFUSED  = 2'd3;

  // Allocation kinds.
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REUSE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SERVER_W-1:0] server;
    logic [CHAN_W-1:0]   index;
    logic                idx_ok;
  } aca_req_t;

  typedef struct packed {
    logic [CHANNELS-1:0] busy;
    logic [COUNT_W-1:0]  free_total;
  } aca_stat_t;

endpackage

### hdl/affinity_channel_allocator_core.sv
// Affinity channel allocator: eight channels, each free or busy and tagged with
// the server it last served. Requests arrive on the in_ channel (valid/ready):
// allocate for in_server_id, free in_channel_index, or claim in_channel_index if
// it is free. Every request yields exactly one result on the out_ channel with a
// status, the channel, the allocation kind and the free-channel count after it.
// A two-entry queue sits behind the input, so requests are taken while the back
// end works or while a result waits at the output register.
// Free, claim and unknown requests are handled in S_IDLE with a registered
// result, one request per cycle sustained while the output accepts results.
// Allocations scan the table one channel per cycle and stop early on a
// same-server hit, then grant in S_FIN; the back end takes no new request
// until that result is registered. The scan uses the table's single read port.
// Reset marks every channel free and never used and sets the free count to 8.
// When out_ready is low the result holds in the output register; the back end
// stalls before its next result and in_ready falls once the queue holds two.
module affinity_channel_allocator_core
  import aca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [SERVER_W-1:0] in_server_id,
  input  logic [CHAN_W-1:0]   in_channel_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [KIND_W-1:0]   out_alloc_kind,
  output logic [COUNT_W-1:0]  out_free_count
);

`include "affinity_channel_allocator_core_assert.svh"

  logic      q_valid;
  logic      q_pop;
  aca_req_t  q_entry;
  aca_stat_t stat;

  aca_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_server_id     (in_server_id),
    .in_channel_index (in_channel_index),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop)
  );

  aca_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_channel    (out_channel),
    .out_alloc_kind (out_alloc_kind),
    .out_free_count (out_free_count),
    .stat           (stat)
  );

  // The free count always matches the number of channels not marked busy.
  `ACA_ASSERT(a_free_matches_busy, (32'(stat.free_total) + $countones(stat.busy)) == CHANNELS, "free count out of step with busy flags")

  // A no-free answer is only given when every channel is busy.
  `ACA_ASSERT_IMP(a_nofree_empty, out_valid && (out_status == STAT_NOFREE), out_free_count == '0, "no-free status with free channels left")

  // Any allocation kind other than none comes with a successful grant.
  `ACA_ASSERT_IMP(a_kind_done, out_valid && (out_alloc_kind != KIND_NONE), out_status == STAT_DONE, "allocation kind reported without a grant")

endmodule

### hdl/aca_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on aca_pkg.
module aca_front
  import aca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [SERVER_W-1:0] in_server_id,
  input  logic [CHAN_W-1:0]   in_channel_index,
  output logic                q_valid,
  output aca_req_t            q_entry,
  input  logic                q_pop
);

  aca_req_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  aca_req_t          entry_in;
  logic              push;

  always_comb begin
    entry_in.server = in_server_id;
    entry_in.index  = in_channel_index;
    entry_in.idx_ok = (32'(in_channel_index) < CHANNELS);
    case (in_operation)
      OP_ALLOC: entry_in.kind = REQ_ALLOC;
      OP_FREE:  entry_in.kind = REQ_FREE;
      OP_CLAIM: entry_in.kind = REQ_CLAIM;
      default:  entry_in.kind = REQ_NOP;
    endcase
  end

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_entry  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

### hdl/aca_back.sv
// Back end: holds the channel table, scans it one entry a cycle for allocations,
// applies free and claim requests and drives the result register. Depends on aca_pkg.
module aca_back
  import aca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  aca_req_t            q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [KIND_W-1:0]   out_alloc_kind,
  output logic [COUNT_W-1:0]  out_free_count,
  output aca_stat_t           stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CHANNELS-1:0] busy_r, busy_nxt;
  logic [CHANNELS-1:0] used_r, used_nxt;
  logic [SERVER_W-1:0] server_r [CHANNELS];
  logic [SERVER_W-1:0] server_nxt [CHANNELS];
  logic [COUNT_W-1:0]  free_r, free_nxt;

  logic [CHAN_W-1:0]   scan_r, scan_nxt;
  logic [SERVER_W-1:0] req_server_r, req_server_nxt;
  logic                hit_r, hit_nxt, fresh_r, fresh_nxt, other_r, other_nxt;
  logic [CHAN_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [CHAN_W-1:0]   fresh_idx_r, fresh_idx_nxt;
  logic [CHAN_W-1:0]   other_idx_r, other_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [CHAN_W-1:0]   out_channel_r, out_channel_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [COUNT_W-1:0]  out_free_r, out_free_nxt;

  logic [CHAN_W-1:0]   rd_idx;
  logic                busy_rd, used_rd, hit_now, slot_free, granted;
  logic [SERVER_W-1:0] server_rd;
  logic [CHAN_W-1:0]   pick;
  logic [KIND_W-1:0]   pick_kind;

  // A single table read port, shared between request lookup and the scan.
  assign rd_idx    = (state_r == S_IDLE) ? q_entry.index : scan_r;
  assign busy_rd   = busy_r[rd_idx];
  assign used_rd   = used_r[rd_idx];
  assign server_rd = server_r[rd_idx];
  assign hit_now   = !busy_rd && used_rd && (server_rd == req_server_r);
  assign slot_free = !out_valid_r || out_ready;

  // Priority among the scan results: same server, then never used, then reuse.
  always_comb begin
    granted   = 1'b1;
    pick      = '0;
    pick_kind = KIND_NONE;
    if (hit_r) begin
      pick      = hit_idx_r;
      pick_kind = KIND_HIT;
    end else if (fresh_r) begin
      pick      = fresh_idx_r;
      pick_kind = KIND_NEW;
    end else if (other_r) begin
      pick      = other_idx_r;
      pick_kind = KIND_REUSE;
    end else begin
      granted   = 1'b0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    busy_nxt        = busy_r;
    used_nxt        = used_r;
    server_nxt      = server_r;
    free_nxt        = free_r;
    scan_nxt        = scan_r;
    req_server_nxt  = req_server_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    fresh_nxt       = fresh_r;
    fresh_idx_nxt   = fresh_idx_r;
    other_nxt       = other_r;
    other_idx_nxt   = other_idx_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_channel_nxt = out_channel_r;
    out_kind_nxt    = out_kind_r;
    out_free_nxt    = out_free_r;
    q_pop           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_entry.kind)
            REQ_ALLOC: begin
              req_server_nxt = q_entry.server;
              scan_nxt       = '0;
              hit_nxt        = 1'b0;
              fresh_nxt      = 1'b0;
              other_nxt      = 1'b0;
              state_nxt      = S_SCAN;
            end
            REQ_FREE: begin
              out_valid_nxt   = 1'b1;
              out_channel_nxt = q_entry.index;
              out_kind_nxt    = KIND_NONE;
              if (q_entry.idx_ok && busy_rd) begin
                busy_nxt[q_entry.index] = 1'b0;
                if (32'(free_r) < CHANNELS) begin
                  free_nxt = free_r + 1'b1;
                end
                out_status_nxt = STAT_DONE;
              end else begin
                out_status_nxt = STAT_FREEFREE;
              end
              out_free_nxt = free_nxt;
            end
            REQ_CLAIM: begin
              out_valid_nxt   = 1'b1;
              out_channel_nxt = q_entry.index;
              out_kind_nxt    = KIND_NONE;
              if (q_entry.idx_ok && !busy_rd) begin
                busy_nxt[q_entry.index] = 1'b1;
                if (free_r != '0) begin
                  free_nxt = free_r - 1'b1;
                end
                out_status_nxt = STAT_DONE;
              end else begin
                out_status_nxt = STAT_REFUSED;
              end
              out_free_nxt = free_nxt;
            end
            default: begin
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STAT_DONE;
              out_channel_nxt = '0;
              out_kind_nxt    = KIND_NONE;
              out_free_nxt    = free_r;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!busy_rd) begin
          if (!used_rd) begin
            if (!fresh_r) begin
              fresh_nxt     = 1'b1;
              fresh_idx_nxt = scan_r;
            end
          end else if (hit_now) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = scan_r;
          end else if (!other_r) begin
            other_nxt     = 1'b1;
            other_idx_nxt = scan_r;
          end
        end
        if (hit_now || (scan_r == CHAN_W'(CHANNELS - 1))) begin
          state_nxt = S_FIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (granted) begin
            busy_nxt[pick] = 1'b1;
            // A same-server hit keeps its tag; other grants are retagged.
            if (pick_kind != KIND_HIT) begin
              used_nxt[pick]   = 1'b1;
              server_nxt[pick] = req_server_r;
            end
            if (free_r != '0) begin
              free_nxt = free_r - 1'b1;
            end
            out_status_nxt  = STAT_DONE;
            out_channel_nxt = pick;
            out_kind_nxt    = pick_kind;
          end else begin
            out_status_nxt  = STAT_NOFREE;
            out_channel_nxt = '0;
            out_kind_nxt    = KIND_NONE;
          end
          out_free_nxt = free_nxt;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      used_r      <= '0;
      free_r      <= COUNT_W'(CHANNELS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    server_r      <= server_nxt;
    scan_r        <= scan_nxt;
    req_server_r  <= req_server_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    fresh_r       <= fresh_nxt;
    fresh_idx_r   <= fresh_idx_nxt;
    other_r       <= other_nxt;
    other_idx_r   <= other_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_channel_r <= out_channel_nxt;
    out_kind_r    <= out_kind_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_channel     = out_channel_r;
  assign out_alloc_kind  = out_kind_r;
  assign out_free_count  = out_free_r;
  assign stat.busy       = busy_r;
  assign stat.free_total = free_r;

endmodule

### dv/affinity_channel_allocator_core_tb.sv
// Self-checking testbench for affinity_channel_allocator_core.
// Depends on aca_pkg for widths and codes; it predicts every result from its own
// copy of the channel table and checks the results in order on the out_ channel.
module affinity_channel_allocator_core_tb;
  import aca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The operation field is two bits wide, so one code has no meaning.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CHAN_W-1:0]  channel;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } grant_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = '0;
  logic [SERVER_W-1:0] in_server_id = '0;
  logic [CHAN_W-1:0]   in_channel_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [CHAN_W-1:0]   out_channel;
  logic [KIND_W-1:0]   out_alloc_kind;
  logic [COUNT_W-1:0]  out_free_count;

  // Predicted channel table.
  logic                chan_busy_q [CHANNELS];
  logic                chan_used_q [CHANNELS];
  logic [SERVER_W-1:0] chan_owner_q [CHANNELS];
  logic [COUNT_W-1:0]  free_cnt;

  grant_result_t expected_grants[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_hit = 0, n_new = 0, n_reuse = 0, n_nofree = 0, n_double_free = 0, n_refused = 0;

  affinity_channel_allocator_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_server_id     (in_server_id),
    .in_channel_index (in_channel_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_channel      (out_channel),
    .out_alloc_kind   (out_alloc_kind),
    .out_free_count   (out_free_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_grants.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Applies one request to the predicted table and returns the result it gives.
  function automatic grant_result_t predict_grant(input logic [OP_W-1:0] op,
                                                  input logic [SERVER_W-1:0] srv,
                                                  input logic [CHAN_W-1:0] idx);
    grant_result_t res;
    int hit, fresh, other, pick;
    res.status  = STAT_DONE;
    res.channel = '0;
    res.kind    = KIND_NONE;
    hit = -1;
    fresh = -1;
    other = -1;
    pick = -1;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (!chan_busy_q[i]) begin
            if (!chan_used_q[i]) begin
              if (fresh < 0) fresh = i;
            end else if (chan_owner_q[i] == srv) begin
              hit = i;
              break;
            end else if (other < 0) begin
              other = i;
            end
          end
        end
        if (hit >= 0) begin
          pick = hit;
          res.kind = KIND_HIT;
          n_hit++;
        end else if (fresh >= 0) begin
          pick = fresh;
          res.kind = KIND_NEW;
          n_new++;
        end else if (other >= 0) begin
          pick = other;
          res.kind = KIND_REUSE;
          n_reuse++;
        end
        if (pick < 0) begin
          res.status = STAT_NOFREE;
          n_nofree++;
        end else begin
          // A same-server hit keeps its tag; the other two retag the channel.
          if (res.kind != KIND_HIT) begin
            chan_used_q[pick] = 1'b1;
            chan_owner_q[pick] = srv;
          end
          chan_busy_q[pick] = 1'b1;
          if (free_cnt > 0) free_cnt--;
          res.channel = pick[CHAN_W-1:0];
        end
      end
      OP_FREE: begin
        res.channel = idx;
        if (!chan_busy_q[idx]) begin
          res.status = STAT_FREEFREE;
          n_double_free++;
        end else begin
          chan_busy_q[idx] = 1'b0;
          if (free_cnt < CHANNELS) free_cnt++;
        end
      end
      OP_CLAIM: begin
        res.channel = idx;
        if (chan_busy_q[idx]) begin
          res.status = STAT_REFUSED;
          n_refused++;
        end else begin
          chan_busy_q[idx] = 1'b1;
          if (free_cnt > 0) free_cnt--;
        end
      end
      default: ;
    endcase
    res.count = free_cnt;
    return res;
  endfunction

  task automatic report_field(input string name, input int exp_val, input int act_val);
    n_errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
  endtask

  always @(posedge clk) begin : check_results
    grant_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected, status %0d channel %0d", $time,
                 out_status, out_channel);
      end else begin
        exp_res = expected_grants.pop_front();
        n_checked++;
        if (out_status !== exp_res.status)
          report_field("status", exp_res.status, out_status);
        if (out_channel !== exp_res.channel)
          report_field("channel", exp_res.channel, out_channel);
        if (out_alloc_kind !== exp_res.kind)
          report_field("alloc_kind", exp_res.kind, out_alloc_kind);
        if (out_free_count !== exp_res.count)
          report_field("free_count", exp_res.count, out_free_count);
      end
    end
  end

  // Presents one request, holds it until the transfer and records its result.
  task automatic send_req(input logic [OP_W-1:0] op, input logic [SERVER_W-1:0] srv,
                          input logic [CHAN_W-1:0] idx);
    grant_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_server_id     <= srv;
    in_channel_index <= idx;
    do @(posedge clk); while (!in_ready);
    res = predict_grant(op, srv, idx);
    expected_grants.push_back(res);
    n_sent++;
  endtask

  // Holds the input idle until every outstanding result has been seen.
  task automatic drain_outstanding();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_grants.size() != 0);
  endtask

  task automatic test_basic_ops();
    send_req(OP_FREE, 8'd0, 3'd0);        // free of a channel that is already free
    send_req(OP_CLAIM, 8'd0, 3'd7);       // claim keeps the channel never used
    send_req(OP_CLAIM, 8'd0, 3'd7);       // claim of a busy channel is refused
    send_req(OP_UNKNOWN, 8'd255, 3'd7);
  endtask

  task automatic test_affinity();
    send_req(OP_ALLOC, 8'd0, 3'd0);
    send_req(OP_ALLOC, 8'd255, 3'd7);
    send_req(OP_FREE, 8'd0, 3'd0);
    send_req(OP_ALLOC, 8'd0, 3'd5);       // same-server hit on channel 0
  endtask

  task automatic test_full_table();
    for (int s = 1; s <= 5; s++)
      send_req(OP_ALLOC, s[SERVER_W-1:0], 3'd0);
    send_req(OP_ALLOC, 8'd9, 3'd0);       // every channel busy
    drain_outstanding();
  endtask

  task automatic test_reuse();
    send_req(OP_FREE, 8'd0, 3'd7);        // claimed channel that was never used
    send_req(OP_ALLOC, 8'd200, 3'd0);
    send_req(OP_FREE, 8'd0, 3'd3);
    send_req(OP_FREE, 8'd0, 3'd1);
    send_req(OP_ALLOC, 8'd77, 3'd0);      // no hit, no fresh channel: reuse
    send_req(OP_FREE, 8'd0, 3'd6);
    send_req(OP_FREE, 8'd0, 3'd6);
    send_req(OP_ALLOC, 8'd5, 3'd0);
    send_req(OP_ALLOC, 8'd2, 3'd0);
  endtask

  // Mostly allocate/free traffic over a small server pool so that hits, reuse
  // and a full table all recur; claims and unknown codes are mixed in.
  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
    logic [SERVER_W-1:0] pool [4];
    logic [OP_W-1:0]     op;
    logic [SERVER_W-1:0] srv;
    logic [CHAN_W-1:0]   idx;
    int roll, p_alloc, start;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    pool[0] = 8'h00;
    pool[1] = 8'hFF;
    pool[2] = SERVER_W'($urandom_range(255));
    pool[3] = SERVER_W'($urandom_range(255));
    for (int n = 0; n < n_items; n++) begin
      srv = ($urandom_range(99) < 60) ? pool[$urandom_range(3)]
                                      : SERVER_W'($urandom_range(255));
      idx = CHAN_W'($urandom_range(CHANNELS - 1));
      roll = $urandom_range(99);
      if (free_cnt == 0) p_alloc = 25;
      else if (free_cnt == CHANNELS) p_alloc = 90;
      else p_alloc = 55;
      if (roll < 4) begin
        op = OP_UNKNOWN;
      end else if (roll < 12) begin
        op = OP_CLAIM;
      end else if ($urandom_range(99) < p_alloc) begin
        op = OP_ALLOC;
      end else begin
        op = OP_FREE;
        // Usually free a channel that is really busy.
        if ($urandom_range(99) < 80) begin
          start = $urandom_range(CHANNELS - 1);
          for (int k = 0; k < CHANNELS; k++)
            if (chan_busy_q[(start + k) % CHANNELS]) begin
              idx = CHAN_W'((start + k) % CHANNELS);
              break;
            end
        end
      end
      send_req(op, srv, idx);
      if (n % 120 == 119) drain_outstanding();
    end
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_busy_q[i] = 1'b0;
      chan_used_q[i] = 1'b0;
      chan_owner_q[i] = '0;
    end
    free_cnt = COUNT_W'(CHANNELS);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_idle_pct = 40;
    test_basic_ops();
    test_affinity();
    test_full_table();
    test_reuse();
    test_random_traffic(360, 17, 83);
    test_random_traffic(360, 83, 17);
    test_random_traffic(360, 0, 0);
    drain_outstanding();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d affinity hits, %0d fresh grants, %0d reuses, %0d full.",
             n_sent, n_hit, n_new, n_reuse, n_nofree);
    $display("Saw %0d double frees and %0d refused claims; %0d results checked.",
             n_double_free, n_refused, n_checked);
    if (n_errors == 0 && expected_grants.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors, %0d results never arrived", n_errors, expected_grants.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### affinity_channel_allocator_core.f
+incdir+hdl
hdl/aca_pkg.sv
hdl/aca_front.sv
hdl/aca_back.sv
hdl/affinity_channel_allocator_core.sv
dv/affinity_channel_allocator_core_tb.sv
